// ===== rtl/lpfa_pkg.sv =====
package lpfa_pkg;

    localparam int NUM_PARTICLES_DEF = 512;

    localparam int IDX_W  = 9;
    localparam int POS_W  = 24;
    localparam int BOX_W  = 24;
    localparam int CUT_W  = 32;
    localparam int SUM_W  = 32;
    localparam int TYPE_W = 2;

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 144;

    localparam int D_W   = 27;
    localparam int DM_W  = 26;
    localparam int R_W   = 52;
    localparam int R2_W  = 36;
    localparam int Q_W   = 33;
    localparam int MAG_W = 47;
    localparam int DF_W  = 53;

    localparam int MA_W   = 53;
    localparam int MB_W   = 48;
    localparam int MC_W   = 16;
    localparam int MUL_NCH = 3;
    localparam int MP_W   = MA_W + MB_W;

    localparam logic [TYPE_W-1:0] REQ_ACCUM = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_READ  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic CFG_BOX = 1'b0;
    localparam logic CFG_CUT = 1'b1;

    localparam logic [BOX_W-1:0] BOX_RST = 24'd524288;
    localparam logic [CUT_W-1:0] CUT_RST = 32'd1638400;

    typedef struct packed {
        logic              sat;
        logic [SUM_W-1:0]  pot;
        logic [SUM_W-1:0]  az;
        logic [SUM_W-1:0]  ay;
        logic [SUM_W-1:0]  ax;
    } t_entry;

    localparam int ENTRY_W = 1 + 4 * SUM_W;

endpackage

// ===== rtl/lpfa_ram.sv =====
module lpfa_ram #(
    parameter int WIDTH = lpfa_pkg::ENTRY_W,
    parameter int DEPTH = lpfa_pkg::NUM_PARTICLES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lpfa_mul.sv =====
module lpfa_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lpfa_pkg::MA_W-1:0]  i_a,
    input  logic [lpfa_pkg::MB_W-1:0]  i_b,
    output logic                       o_done,
    output logic [lpfa_pkg::MP_W-1:0]  o_p
);

    logic [lpfa_pkg::MA_W-1:0]                 r_a;
    logic [lpfa_pkg::MB_W-1:0]                 r_b;
    logic [lpfa_pkg::MP_W-1:0]                 r_acc;
    logic [1:0]                                r_cnt;
    logic                                      r_busy;
    logic                                      r_done;
    logic [lpfa_pkg::MC_W-1:0]                 chunk;
    logic [lpfa_pkg::MA_W+lpfa_pkg::MC_W-1:0]  pp;
    logic [lpfa_pkg::MP_W-1:0]                 n_acc;

    // msb chunk first, shift accumulator up each step
    assign chunk = r_b[lpfa_pkg::MB_W-1 -: lpfa_pkg::MC_W];
    assign pp    = r_a * chunk;
    assign n_acc = (r_acc << lpfa_pkg::MC_W) + lpfa_pkg::MP_W'(pp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_b   <= r_b << lpfa_pkg::MC_W;
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'(lpfa_pkg::MUL_NCH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

// ===== rtl/lj_pair_force_accumulator_core.sv =====
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata: pair indices and positions, tuser: kind
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: particle sums, tuser: saturated flag
// cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_index, i_cfg_data
//
// an accumulate item uses up to twelve products on the shared
// 53x16 multiplier plus a 33-step restoring divider for 1/r^2.
// a read passes a wait state, then an output state; a clear sweeps the whole sum memory.
// after reset the same sweep runs before the first transfer.
// a read waits while the output register still holds an untaken result.
module lj_pair_force_accumulator_core #(
    parameter int NUM_PARTICLES = lpfa_pkg::NUM_PARTICLES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // index_i, index_j, pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z
    input  logic [lpfa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // req_type
    input  logic [lpfa_pkg::TYPE_W-1:0]      s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // particle_index, accel_x, accel_y, accel_z, potential
    output logic [lpfa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // saturated
    output logic                             m_axis_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [lpfa_pkg::CUT_W-1:0]       i_cfg_data
);

    localparam int AW = $clog2(NUM_PARTICLES);
    localparam int XW = (AW > lpfa_pkg::IDX_W) ? AW : lpfa_pkg::IDX_W;

    localparam logic [3:0] S_CLR     = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_MGO     = 4'd2;
    localparam logic [3:0] S_MWAIT   = 4'd3;
    localparam logic [3:0] S_DIV     = 4'd4;
    localparam logic [3:0] S_POST    = 4'd5;
    localparam logic [3:0] S_AP_RD   = 4'd6;
    localparam logic [3:0] S_AP_WR   = 4'd7;
    localparam logic [3:0] S_RD_WAIT = 4'd8;
    localparam logic [3:0] S_RD_OUT  = 4'd9;

    localparam logic [2:0] OP_DSQ = 3'd0;
    localparam logic [2:0] OP_S2  = 3'd1;
    localparam logic [2:0] OP_S3  = 3'd2;
    localparam logic [2:0] OP_S6  = 3'd3;
    localparam logic [2:0] OP_T   = 3'd4;
    localparam logic [2:0] OP_A   = 3'd5;

    localparam logic signed [31:0] SMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SMIN = 32'sh80000000;

    function automatic logic [AW-1:0] f_addr(input logic [lpfa_pkg::IDX_W-1:0] idx);
        logic [XW-1:0] w;
        begin
            w = XW'(idx);
            f_addr = w[AW-1:0];
        end
    endfunction

    function automatic logic f_inrange(input logic [lpfa_pkg::IDX_W-1:0] idx);
        f_inrange = (32'(idx) < 32'(NUM_PARTICLES));
    endfunction

    function automatic logic signed [lpfa_pkg::D_W-1:0] f_wrap(
        input logic [lpfa_pkg::POS_W-1:0] a,
        input logic [lpfa_pkg::POS_W-1:0] b,
        input logic [lpfa_pkg::BOX_W-1:0] box
    );
        logic signed [27:0] d;
        logic signed [27:0] bx;
        begin
            bx = $signed({4'b0, box});
            d  = $signed({4'b0, a}) - $signed({4'b0, b});
            if ((d <<< 1) > bx) d = d - bx;
            if ((d <<< 1) < -bx) d = d + bx;
            f_wrap = d[lpfa_pkg::D_W-1:0];
        end
    endfunction

    // saturating add, returns {clip, sum}
    function automatic logic [32:0] f_sadd(
        input logic [31:0]        x,
        input logic signed [33:0] v
    );
        logic signed [34:0] s;
        begin
            s = $signed({{3{x[31]}}, x}) + $signed({v[33], v});
            if (s > 35'sd2147483647) f_sadd = {1'b1, SMAX};
            else if (s < -35'sd2147483648) f_sadd = {1'b1, SMIN};
            else f_sadd = {1'b0, s[31:0]};
        end
    endfunction

    logic [3:0]                        r_state;
    logic [AW-1:0]                     r_cnt;
    logic [2:0]                        r_op;
    logic [1:0]                        r_k;
    logic                              r_pass;
    logic                              r_huge;
    logic                              r_mvalid;
    logic [lpfa_pkg::BOX_W-1:0]        r_box;
    logic [lpfa_pkg::CUT_W-1:0]        r_cut;
    logic [5:0]                        r_dcnt;

    logic signed [lpfa_pkg::D_W-1:0]   r_d [3];
    logic [lpfa_pkg::R_W-1:0]          r_r;
    logic [lpfa_pkg::Q_W-1:0]          r_s;
    logic [lpfa_pkg::MAG_W-1:0]        r_s2;
    logic [lpfa_pkg::MAG_W-1:0]        r_s3;
    logic [lpfa_pkg::MAG_W-1:0]        r_s6;
    logic [lpfa_pkg::MAG_W-1:0]        r_t;
    logic [lpfa_pkg::DF_W-1:0]         r_dfmag;
    logic                              r_dfneg;
    logic [31:0]                       r_pot;
    logic [31:0]                       r_accel [3];
    logic                              r_clip;
    logic [lpfa_pkg::IDX_W-1:0]        r_ii;
    logic [lpfa_pkg::IDX_W-1:0]        r_jj;
    logic [AW-1:0]                     r_addr;
    logic [lpfa_pkg::R2_W-1:0]         r_rem;
    logic [lpfa_pkg::Q_W-1:0]          r_q;
    logic [lpfa_pkg::OUT_DATA_W-1:0]   r_mdata;
    logic                              r_muser;

    logic                              s_xfer;
    logic                              mul_start;
    logic                              mul_done;
    logic [lpfa_pkg::MA_W-1:0]         mul_a;
    logic [lpfa_pkg::MB_W-1:0]         mul_b;
    logic [lpfa_pkg::MP_W-1:0]         mul_p;
    logic [lpfa_pkg::MAG_W-1:0]        umag;
    logic signed [lpfa_pkg::D_W-1:0]   dk;
    logic [lpfa_pkg::D_W-1:0]          dneg;
    logic [lpfa_pkg::DM_W-1:0]         dmag;
    logic [lpfa_pkg::R_W-1:0]          rsum;
    logic                              amag_neg;
    logic [31:0]                       n_acc_k;
    logic                              n_acc_clip;
    logic [lpfa_pkg::R2_W:0]           rem_sh;
    logic                              div_ge;
    logic [lpfa_pkg::R2_W:0]           rem_sub;
    logic signed [50:0]                pot4;
    logic signed [lpfa_pkg::DF_W-1:0]  diff;
    logic                              ram_we;
    logic [AW-1:0]                     ram_waddr;
    lpfa_pkg::t_entry                  ram_wdata;
    lpfa_pkg::t_entry                  ram_rdata;
    lpfa_pkg::t_entry                  upd;
    logic [32:0]                       add_p;
    logic [32:0]                       add_x;
    logic [32:0]                       add_y;
    logic [32:0]                       add_z;
    logic [lpfa_pkg::IDX_W-1:0]        cur_idx;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // operand selection for the shared multiplier
    assign dk   = r_d[r_k];
    assign dneg = 27'(0) - dk;
    assign dmag = dk[lpfa_pkg::D_W-1] ? dneg[lpfa_pkg::DM_W-1:0] : dk[lpfa_pkg::DM_W-1:0];

    always_comb begin
        case (r_op)
            OP_DSQ: begin
                mul_a = lpfa_pkg::MA_W'(dmag);
                mul_b = lpfa_pkg::MB_W'(dmag);
            end
            OP_S2: begin
                mul_a = lpfa_pkg::MA_W'(r_s);
                mul_b = lpfa_pkg::MB_W'(r_s);
            end
            OP_S3: begin
                mul_a = lpfa_pkg::MA_W'(r_s2);
                mul_b = lpfa_pkg::MB_W'(r_s);
            end
            OP_S6: begin
                mul_a = lpfa_pkg::MA_W'(r_s3);
                mul_b = lpfa_pkg::MB_W'(r_s3);
            end
            OP_T: begin
                mul_a = lpfa_pkg::MA_W'(dmag);
                mul_b = lpfa_pkg::MB_W'(r_s);
            end
            OP_A: begin
                mul_a = r_dfmag;
                mul_b = lpfa_pkg::MB_W'(r_t);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_start = (r_state == S_MGO);

    lpfa_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    // capped q16.16 product magnitude
    assign umag = (mul_p > (101'd1 << 62)) ? (47'd1 << 46) : mul_p[62:16];
    assign rsum = r_r + mul_p[lpfa_pkg::R_W-1:0];

    // acceleration clip from product magnitude
    assign amag_neg = r_dfneg ^ dk[lpfa_pkg::D_W-1];
    always_comb begin
        if (amag_neg) begin
            if (umag > 47'd2147483648) begin
                n_acc_k    = SMIN;
                n_acc_clip = 1'b1;
            end else begin
                n_acc_k    = 32'd0 - umag[31:0];
                n_acc_clip = 1'b0;
            end
        end else begin
            if (umag > 47'd2147483647) begin
                n_acc_k    = SMAX;
                n_acc_clip = 1'b1;
            end else begin
                n_acc_k    = umag[31:0];
                n_acc_clip = 1'b0;
            end
        end
    end

    // restoring divider step for 2^32 / r2
    assign rem_sh  = {r_rem, (r_dcnt == 6'd0)};
    assign div_ge  = (rem_sh >= {1'b0, r_r[lpfa_pkg::R_W-1:16]});
    assign rem_sub = rem_sh - {1'b0, r_r[lpfa_pkg::R_W-1:16]};

    assign pot4 = ($signed({4'b0, r_s6}) - $signed({4'b0, r_s3})) <<< 2;
    assign diff = $signed(({6'b0, r_s6} << 5) + ({6'b0, r_s6} << 4))
                - $signed(({6'b0, r_s3} << 4) + ({6'b0, r_s3} << 3));

    // read-modify-write of one particle's sums
    assign cur_idx = r_pass ? r_jj : r_ii;
    assign add_p = f_sadd(ram_rdata.pot, 34'(signed'(r_pot)));
    assign add_x = f_sadd(ram_rdata.ax, r_pass ? -34'(signed'(r_accel[0]))
                                               : 34'(signed'(r_accel[0])));
    assign add_y = f_sadd(ram_rdata.ay, r_pass ? -34'(signed'(r_accel[1]))
                                               : 34'(signed'(r_accel[1])));
    assign add_z = f_sadd(ram_rdata.az, r_pass ? -34'(signed'(r_accel[2]))
                                               : 34'(signed'(r_accel[2])));

    always_comb begin
        upd.pot = add_p[31:0];
        upd.ax  = add_x[31:0];
        upd.ay  = add_y[31:0];
        upd.az  = add_z[31:0];
        upd.sat = ram_rdata.sat | add_p[32] | add_x[32] | add_y[32] | add_z[32] | r_clip;
    end

    always_comb begin
        if (r_state == S_CLR) begin
            ram_we    = 1'b1;
            ram_waddr = r_cnt;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == S_AP_WR) && f_inrange(cur_idx);
            ram_waddr = r_addr;
            ram_wdata = upd;
        end
    end

    lpfa_ram #(
        .WIDTH (lpfa_pkg::ENTRY_W),
        .DEPTH (NUM_PARTICLES)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_op     <= OP_DSQ;
            r_k      <= '0;
            r_pass   <= 1'b0;
            r_huge   <= 1'b0;
            r_mvalid <= 1'b0;
            r_box    <= lpfa_pkg::BOX_RST;
            r_cut    <= lpfa_pkg::CUT_RST;
            r_dcnt   <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lpfa_pkg::CFG_BOX: r_box <= i_cfg_data[lpfa_pkg::BOX_W-1:0];
                    lpfa_pkg::CFG_CUT: r_cut <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_mvalid && m_axis_tready && (r_state != S_RD_OUT)) begin
                r_mvalid <= 1'b0;
            end

            case (r_state)
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == AW'(NUM_PARTICLES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_xfer) begin
                        r_ii   <= s_axis_tdata[8:0];
                        r_jj   <= s_axis_tdata[17:9];
                        r_addr <= f_addr(s_axis_tdata[8:0]);
                        case (s_axis_tuser)
                            lpfa_pkg::REQ_ACCUM: begin
                                r_d[0] <= f_wrap(s_axis_tdata[41:18], s_axis_tdata[113:90], r_box);
                                r_d[1] <= f_wrap(s_axis_tdata[65:42], s_axis_tdata[137:114], r_box);
                                r_d[2] <= f_wrap(s_axis_tdata[89:66], s_axis_tdata[161:138], r_box);
                                r_r     <= '0;
                                r_k     <= '0;
                                r_op    <= OP_DSQ;
                                r_huge  <= 1'b0;
                                r_clip  <= 1'b0;
                                r_state <= S_MGO;
                            end
                            lpfa_pkg::REQ_READ: begin
                                r_state <= S_RD_WAIT;
                            end
                            lpfa_pkg::REQ_CLEAR: begin
                                r_cnt   <= '0;
                                r_state <= S_CLR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MGO: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (mul_done) begin
                        case (r_op)
                            OP_DSQ: begin
                                r_r <= rsum;
                                if (r_k != 2'd2) begin
                                    r_k     <= r_k + 2'd1;
                                    r_state <= S_MGO;
                                end else if (rsum >= lpfa_pkg::R_W'({r_cut, 16'b0})) begin
                                    r_state <= S_IDLE;
                                end else if (rsum[lpfa_pkg::R_W-1:16] == '0) begin
                                    r_huge  <= 1'b1;
                                    r_state <= S_POST;
                                end else begin
                                    r_rem   <= '0;
                                    r_q     <= '0;
                                    r_dcnt  <= '0;
                                    r_state <= S_DIV;
                                end
                            end
                            OP_S2: begin
                                r_s2    <= umag;
                                r_op    <= OP_S3;
                                r_state <= S_MGO;
                            end
                            OP_S3: begin
                                r_s3    <= umag;
                                r_op    <= OP_S6;
                                r_state <= S_MGO;
                            end
                            OP_S6: begin
                                r_s6    <= umag;
                                r_state <= S_POST;
                            end
                            OP_T: begin
                                r_t     <= umag;
                                r_op    <= OP_A;
                                r_state <= S_MGO;
                            end
                            OP_A: begin
                                r_accel[r_k] <= n_acc_k;
                                if (n_acc_clip) r_clip <= 1'b1;
                                if (r_k == 2'd2) begin
                                    r_pass  <= 1'b0;
                                    r_addr  <= f_addr(r_ii);
                                    r_state <= S_AP_RD;
                                end else begin
                                    r_k     <= r_k + 2'd1;
                                    r_op    <= OP_T;
                                    r_state <= S_MGO;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_DIV: begin
                    r_rem  <= div_ge ? rem_sub[lpfa_pkg::R2_W-1:0] : rem_sh[lpfa_pkg::R2_W-1:0];
                    r_q    <= {r_q[lpfa_pkg::Q_W-2:0], div_ge};
                    r_dcnt <= r_dcnt + 6'd1;
                    if (r_dcnt == 6'(lpfa_pkg::Q_W - 1)) begin
                        r_s     <= {r_q[lpfa_pkg::Q_W-2:0], div_ge};
                        r_op    <= OP_S2;
                        r_state <= S_MGO;
                    end
                end
                S_POST: begin
                    if (r_huge || r_s6[lpfa_pkg::MAG_W-1]) begin
                        // very close pair
                        r_pot  <= SMAX;
                        r_clip <= 1'b1;
                        for (int k = 0; k < 3; k++) begin
                            r_accel[k] <= r_d[k][lpfa_pkg::D_W-1] ? SMIN :
                                          ((r_d[k] != '0) ? SMAX : 32'd0);
                        end
                        r_pass  <= 1'b0;
                        r_addr  <= f_addr(r_ii);
                        r_state <= S_AP_RD;
                    end else begin
                        if (pot4 > 51'sd2147483647) begin
                            r_pot  <= SMAX;
                            r_clip <= 1'b1;
                        end else if (pot4 < -51'sd2147483648) begin
                            r_pot  <= SMIN;
                            r_clip <= 1'b1;
                        end else begin
                            r_pot <= pot4[31:0];
                        end
                        r_dfneg <= diff[lpfa_pkg::DF_W-1];
                        r_dfmag <= diff[lpfa_pkg::DF_W-1] ? (53'd0 - diff) : diff;
                        r_k     <= '0;
                        r_op    <= OP_T;
                        r_state <= S_MGO;
                    end
                end
                S_AP_RD: begin
                    r_state <= S_AP_WR;
                end
                S_AP_WR: begin
                    if (!r_pass) begin
                        r_pass  <= 1'b1;
                        r_addr  <= f_addr(r_jj);
                        r_state <= S_AP_RD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_RD_WAIT: begin
                    r_state <= S_RD_OUT;
                end
                S_RD_OUT: begin
                    if (!r_mvalid || m_axis_tready) begin
                        r_mvalid <= 1'b1;
                        if (f_inrange(r_ii)) begin
                            r_mdata <= {7'b0, ram_rdata.pot, ram_rdata.az, ram_rdata.ay,
                                        ram_rdata.ax, r_ii};
                            r_muser <= ram_rdata.sat;
                        end else begin
                            r_mdata <= {135'b0, r_ii};
                            r_muser <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_mdata;
    assign m_axis_tuser  = r_muser;

endmodule
